@@ hw/rtl/csbd_pkg.sv @@
// Shared types, codes and helpers for the serial bridge receive deframer.
// No dependencies; imported by the parser, the top level and the checker.
package csbd_pkg;

  // Parser state codes
  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_CMD     = 4'd1;
  localparam logic [3:0] ST_CAN     = 4'd2;
  localparam logic [3:0] ST_FD      = 4'd3;
  localparam logic [3:0] ST_TSYNC   = 4'd4;
  localparam logic [3:0] ST_DIG     = 4'd5;
  localparam logic [3:0] ST_ANA     = 4'd6;
  localparam logic [3:0] ST_PARAMS  = 4'd7;
  localparam logic [3:0] ST_DEVINFO = 4'd8;
  localparam logic [3:0] ST_NBUS    = 4'd9;
  localparam logic [3:0] ST_EXTBUS  = 4'd10;
  localparam logic [3:0] ST_FDSET   = 4'd11;

  // Command bytes following the start byte
  localparam logic [7:0] CMD_CAN     = 8'd0;
  localparam logic [7:0] CMD_TSYNC   = 8'd1;
  localparam logic [7:0] CMD_DIG     = 8'd2;
  localparam logic [7:0] CMD_ANA     = 8'd3;
  localparam logic [7:0] CMD_NOP_A   = 8'd4;
  localparam logic [7:0] CMD_NOP_B   = 8'd5;
  localparam logic [7:0] CMD_PARAMS  = 8'd6;
  localparam logic [7:0] CMD_DEVINFO = 8'd7;
  localparam logic [7:0] CMD_VALID   = 8'd9;
  localparam logic [7:0] CMD_NBUS    = 8'd12;
  localparam logic [7:0] CMD_EXTBUS  = 8'd13;
  localparam logic [7:0] CMD_FD      = 8'd20;
  localparam logic [7:0] CMD_FDSET   = 8'd22;

  localparam logic [7:0] START_BYTE = 8'hF1;

  // Result kinds
  localparam logic [3:0] KIND_HEADER  = 4'd0;
  localparam logic [3:0] KIND_PAYLOAD = 4'd1;
  localparam logic [3:0] KIND_FD_END  = 4'd2;
  localparam logic [3:0] KIND_VALID   = 4'd3;
  localparam logic [3:0] KIND_TSYNC   = 4'd4;
  localparam logic [3:0] KIND_BUS0    = 4'd5;
  localparam logic [3:0] KIND_BUS1    = 4'd6;
  localparam logic [3:0] KIND_DEVINFO = 4'd7;
  localparam logic [3:0] KIND_NBUS    = 4'd8;
  localparam logic [3:0] KIND_EXTBUS  = 4'd9;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_OFFSET = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPT_SUSP   = 1'd1;

  // Payload length ceiling
  localparam logic [5:0] FD_MAX_LEN = 6'd63;

  typedef struct packed {
    logic [3:0]  parser_state;
    logic [6:0]  step_count;
    logic [31:0] stamp_accum;
    logic [31:0] word_accum;
    logic [5:0]  payload_len;
    logic [7:0]  flag_byte;
  } parse_state_t;

  typedef struct packed {
    logic [3:0]         kind;
    logic [31:0]        value;
    logic               extended;
    logic               fd_frame;
    logic [5:0]         length;
    logic signed [33:0] timestamp;
    logic [7:0]         data_byte;
    logic [5:0]         byte_index;
    logic               enabled;
    logic               listen_only;
    logic [7:0]         aux;
    logic               last;
  } result_t;

  function automatic logic [5:0] sat_len(input logic [5:0] raw);
    return (raw > FD_MAX_LEN) ? FD_MAX_LEN : raw;
  endfunction

  // LSB-first word assembly
  function automatic logic [31:0] shift_in(input logic [31:0] acc, input logic [7:0] c);
    return {c, acc[31:8]};
  endfunction

endpackage

@@ hw/rtl/csbd_parser.sv @@
// One-byte step of the deframer: next parser state and optional result.
// Pure combinational; depends on csbd_pkg.
module csbd_parser (
  input  csbd_pkg::parse_state_t cur,
  input  logic [7:0]             rx_byte,
  input  logic [31:0]            time_offset,
  input  logic                   capture_suspended,
  output csbd_pkg::parse_state_t nxt,
  output logic                   res_valid,
  output csbd_pkg::result_t      res
);
  import csbd_pkg::*;

  logic [6:0] s;
  logic [6:0] idx;
  logic [5:0] len_new;
  logic [1:0] grp;
  logic [6:0] pos;
  logic       go_idle;
  logic       frame_res;

  assign s = cur.step_count;

  always_comb begin
    nxt            = cur;
    nxt.step_count = s + 7'd1;
    res            = '0;
    res_valid      = 1'b0;
    frame_res      = 1'b0;
    go_idle        = 1'b0;
    idx            = '0;
    len_new        = '0;
    grp            = '0;
    pos            = '0;

    unique case (cur.parser_state)
      ST_CMD: begin
        nxt.step_count = '0;
        unique case (rx_byte)
          CMD_CAN:     nxt.parser_state = ST_CAN;
          CMD_TSYNC:   nxt.parser_state = ST_TSYNC;
          CMD_DIG:     nxt.parser_state = ST_DIG;
          CMD_ANA:     nxt.parser_state = ST_ANA;
          CMD_NOP_A,
          CMD_NOP_B:   nxt.parser_state = ST_IDLE;
          CMD_PARAMS:  nxt.parser_state = ST_PARAMS;
          CMD_DEVINFO: nxt.parser_state = ST_DEVINFO;
          CMD_VALID: begin
            res.kind         = KIND_VALID;
            res_valid        = 1'b1;
            nxt.parser_state = ST_IDLE;
          end
          CMD_NBUS:    nxt.parser_state = ST_NBUS;
          CMD_EXTBUS:  nxt.parser_state = ST_EXTBUS;
          CMD_FD:      nxt.parser_state = ST_FD;
          CMD_FDSET:   nxt.parser_state = ST_FDSET;
          default:     nxt.parser_state = ST_CMD;  // unknown: keep waiting
        endcase
      end

      ST_CAN, ST_FD: begin
        if (s < 7'd4) begin
          nxt.stamp_accum = shift_in(cur.stamp_accum, rx_byte);
        end else if (s < 7'd8) begin
          nxt.word_accum = shift_in(cur.word_accum, rx_byte);
        end else if (cur.parser_state == ST_CAN) begin
          if (s == 7'd8) begin
            len_new         = sat_len({2'b00, rx_byte[3:0]});
            nxt.payload_len = len_new;
            frame_res       = 1'b1;
            res.kind        = KIND_HEADER;
            res.value       = {1'b0, cur.word_accum[30:0]};
            res.extended    = cur.word_accum[31];
            res.length      = len_new;
            res.timestamp   = $signed({2'b00, cur.stamp_accum}) +
                              $signed({{2{time_offset[31]}}, time_offset});
            res.aux         = {4'd0, rx_byte[7:4]};
            res.last        = (len_new == '0);
            go_idle         = (len_new == '0);
          end else begin
            idx = s - 7'd9;
            if (idx >= {1'b0, cur.payload_len}) begin
              go_idle = 1'b1;
            end else begin
              frame_res      = 1'b1;
              res.kind       = KIND_PAYLOAD;
              res.data_byte  = rx_byte;
              res.byte_index = idx[5:0];
              res.last       = (idx + 7'd1 == {1'b0, cur.payload_len});
              go_idle        = res.last;
            end
          end
        end else begin
          if (s == 7'd8) begin
            nxt.payload_len = sat_len(rx_byte[5:0]);
          end else if (s == 7'd9) begin
            frame_res     = 1'b1;
            res.kind      = KIND_HEADER;
            res.value     = {1'b0, cur.word_accum[30:0]};
            res.extended  = cur.word_accum[31];
            res.fd_frame  = 1'b1;
            res.length    = cur.payload_len;
            res.timestamp = $signed({2'b00, cur.stamp_accum}) +
                            $signed({{2{time_offset[31]}}, time_offset});
            res.aux       = rx_byte;
          end else begin
            idx = s - 7'd10;
            frame_res = 1'b1;
            if (idx < {1'b0, cur.payload_len}) begin
              res.kind       = KIND_PAYLOAD;
              res.data_byte  = rx_byte;
              res.byte_index = idx[5:0];
            end else begin
              res.kind = KIND_FD_END;
              res.last = 1'b1;
              go_idle  = 1'b1;
            end
          end
        end
        if (frame_res && !capture_suspended) res_valid = 1'b1;
        if (!frame_res || capture_suspended) res = '0;
      end

      ST_TSYNC: begin
        nxt.word_accum = shift_in(cur.word_accum, rx_byte);
        if (s >= 7'd3) begin
          res.kind  = KIND_TSYNC;
          res.value = nxt.word_accum;
          res_valid = 1'b1;
          go_idle   = 1'b1;
        end
      end

      ST_DIG: go_idle = (s >= 7'd1);

      ST_ANA: go_idle = (s >= 7'd8);

      ST_PARAMS: begin
        if (s == 7'd0 || s == 7'd5) begin
          nxt.flag_byte = rx_byte;
        end else begin
          nxt.word_accum = shift_in(cur.word_accum, rx_byte);
          if (s == 7'd4 || s >= 7'd9) begin
            res.kind        = (s == 7'd4) ? KIND_BUS0 : KIND_BUS1;
            res.value       = nxt.word_accum;
            res.enabled     = (cur.flag_byte[3:0] != '0);
            res.listen_only = (cur.flag_byte[7:4] != '0);
            res.aux         = (s == 7'd4) ? 8'd0 : {6'd0, cur.flag_byte[7:6]};
            res_valid       = 1'b1;
            go_idle         = (s >= 7'd9);
          end
        end
      end

      ST_DEVINFO: begin
        if (s < 7'd2) begin
          nxt.word_accum = shift_in(cur.word_accum, rx_byte);
        end else if (s >= 7'd5) begin
          res.kind  = KIND_DEVINFO;
          res.value = {16'd0, cur.word_accum[31:16]};
          res.aux   = rx_byte;
          res_valid = 1'b1;
          go_idle   = 1'b1;
        end
      end

      ST_NBUS: begin
        res.kind  = KIND_NBUS;
        res.value = {24'd0, rx_byte};
        res_valid = 1'b1;
        go_idle   = 1'b1;
      end

      ST_EXTBUS: begin
        // three groups of five bytes: flag byte then a 32-bit baud word
        if (s >= 7'd15) begin
          go_idle = 1'b1;
        end else begin
          grp = (s >= 7'd10) ? 2'd2 : ((s >= 7'd5) ? 2'd1 : 2'd0);
          pos = s - 7'(5 * grp);
          if (pos == '0) begin
            nxt.flag_byte = rx_byte;
          end else begin
            nxt.word_accum = shift_in(cur.word_accum, rx_byte);
            if (pos == 7'd4) begin
              res.kind        = KIND_EXTBUS;
              res.value       = nxt.word_accum;
              res.byte_index  = {4'd0, grp};
              res.enabled     = (cur.flag_byte[3:0] != '0);
              res.listen_only = (grp == 2'd0) && (cur.flag_byte[7:4] != '0);
              res_valid       = 1'b1;
              go_idle         = (grp == 2'd2);
            end
          end
        end
      end

      ST_FDSET: begin
        // skip until a start byte
        nxt.step_count = cur.step_count;
        if (rx_byte == START_BYTE) begin
          nxt.parser_state = ST_CMD;
          nxt.step_count   = '0;
        end
      end

      default: begin
        // idle and unused codes
        nxt.parser_state = (rx_byte == START_BYTE) ? ST_CMD : ST_IDLE;
        nxt.step_count   = '0;
      end
    endcase

    if (go_idle) begin
      nxt.parser_state = ST_IDLE;
      nxt.step_count   = '0;
    end

    if (!res_valid) res = '0;
  end

endmodule

@@ hw/rtl/can_serial_bridge_rx_deframer.sv @@
// Top level of the serial bridge receive deframer.
// Depends on csbd_pkg and csbd_parser.
//
// Usage:
//   Bytes of the adapter's binary reply stream enter on the in_ stream, one
//   byte per word. Each accepted byte yields zero or one result word on the
//   out_ stream: frame headers, payload bytes, FD end markers, and the
//   status replies (validation, time sync, bus parameters, device info, bus
//   count, extended bus). out_tuser carries the result kind, out_tlast marks
//   the final word of a frame record.
// Path: an accepted byte waits in the input register, and its result in the
//   result register (two register stages).
// Throughput: one byte per cycle sustained unless out_tready stalls; the
//   parser step is a single combinational pass between those two registers.
// Stall: when out_tready is low the result register holds; the input
//   register still takes one more byte, after which in_tready drops until
//   the result is taken.
// Reset: rst_n low (synchronous) empties both registers, returns the parser
//   to idle and clears time_offset and capture_suspended.
// Configuration: cfg_we writes cfg_wdata to cfg_addr (0 time_offset,
//   1 capture_suspended); write only while the block is idle; not enforced.
module can_serial_bridge_rx_deframer (
  input  logic                             clk,
  input  logic                             rst_n,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [7:0] rx_byte
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [31:0] value, [32] extended, [33] fd_frame, [39:34] length,
  // [73:40] timestamp, [81:74] data_byte, [87:82] byte_index,
  // [88] enabled, [89] listen_only, [97:90] aux, [103:98] zero
  output logic [103:0]                     out_tdata,
  output logic [3:0]                       out_tuser,  // [3:0] kind
  output logic                             out_tlast,  // last
  // configuration
  input  logic                             cfg_we,
  input  logic [csbd_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [31:0]                      cfg_wdata
);
  import csbd_pkg::*;

  // config registers
  logic [31:0]  time_offset_r;
  logic         capt_susp_r;

  // input register
  logic         in_valid_r;
  logic [7:0]   in_byte_r;

  // parser state
  parse_state_t pst_r;
  parse_state_t pst_nxt;

  // result register
  logic         out_valid_r;
  result_t      out_res_r;
  result_t      res_nxt;
  logic         res_valid;

  logic         advance;  // result register may load
  logic         fire;     // buffered byte is processed this cycle

  assign advance   = !out_valid_r || out_tready;
  assign fire      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  csbd_parser u_parser (
    .cur               (pst_r),
    .rx_byte           (in_byte_r),
    .time_offset       (time_offset_r),
    .capture_suspended (capt_susp_r),
    .nxt               (pst_nxt),
    .res_valid         (res_valid),
    .res               (res_nxt)
  );

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_offset_r <= '0;
      capt_susp_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_TIME_OFFSET: time_offset_r <= cfg_wdata;
        REG_CAPT_SUSP:   capt_susp_r   <= cfg_wdata[0];
        default:         ;
      endcase
    end
  end

  // Input register: refills in the same cycle it drains
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) in_byte_r <= in_tdata;
  end

  // Parser state advances once per processed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pst_r <= '{parser_state: ST_IDLE, default: '0};
    end else if (fire) begin
      pst_r <= pst_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_res_r <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tlast  = out_res_r.last;
  assign out_tdata  = {6'd0,
                       out_res_r.aux,
                       out_res_r.listen_only,
                       out_res_r.enabled,
                       out_res_r.byte_index,
                       out_res_r.data_byte,
                       out_res_r.timestamp,
                       out_res_r.length,
                       out_res_r.fd_frame,
                       out_res_r.extended,
                       out_res_r.value};

endmodule

@@ hw/rtl/csbd_checker.sv @@
// Port-level checks for the deframer, bound to the top level.
// Depends on csbd_pkg.
module csbd_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [103:0] out_tdata,
  input logic [3:0]   out_tuser,
  input logic         out_tlast
);
  import csbd_pkg::*;

  // held result stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // nothing comes out right after reset
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // status replies never close a frame record
  a_status_nolast: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != KIND_HEADER) && (out_tuser != KIND_PAYLOAD) &&
    (out_tuser != KIND_FD_END) |-> !out_tlast)
    else $error("tlast on a status reply");

  // classic empty frame: the header is the whole record
  a_empty_classic: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_HEADER) && !out_tdata[33] &&
    (out_tdata[39:34] == 6'd0) |-> out_tlast)
    else $error("empty classic header without tlast");

  // FD end marker always closes the record
  a_fd_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_FD_END) |-> out_tlast)
    else $error("fd end without tlast");

endmodule

bind can_serial_bridge_rx_deframer csbd_checker u_csbd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
